// ----- rtl/evi_pkg.sv -----
package evi_pkg;

	localparam int FILTER_ORDER = 12;
	localparam int HIST_LEN     = FILTER_ORDER - 1;
	localparam int K_W          = $clog2(FILTER_ORDER);
	localparam int HIST_IDX_W   = $clog2(HIST_LEN);

	// configuration register indexes
	localparam logic [1:0] REG_SPOOL_CPR = 2'd0;
	localparam logic [1:0] REG_UPPER_CPR = 2'd1;
	localparam logic [1:0] REG_SPOOL_DIR = 2'd2;
	localparam logic [1:0] REG_UPPER_DIR = 2'd3;

	localparam logic [16:0] CPR_RESET = 17'd8192;
	localparam logic [1:0]  DIR_RESET = 2'b11;

	// floating point unit operations
	localparam logic [2:0] FOP_ADD = 3'd0;
	localparam logic [2:0] FOP_SUB = 3'd1;
	localparam logic [2:0] FOP_MUL = 3'd2;
	localparam logic [2:0] FOP_DIV = 3'd3;
	localparam logic [2:0] FOP_CVT = 3'd4;

	// sequencer steps
	localparam logic [3:0] STEP_CVT_COUNT = 4'd0;
	localparam logic [3:0] STEP_SCALE     = 4'd1;
	localparam logic [3:0] STEP_CVT_CPR   = 4'd2;
	localparam logic [3:0] STEP_DIV       = 4'd3;
	localparam logic [3:0] STEP_MUL_B0    = 4'd4;
	localparam logic [3:0] STEP_MUL_B     = 4'd5;
	localparam logic [3:0] STEP_ADD       = 4'd6;
	localparam logic [3:0] STEP_MUL_A     = 4'd7;
	localparam logic [3:0] STEP_SUB       = 4'd8;

	localparam logic [63:0] FP_DNAN      = 64'hFFF8_0000_0000_0000;
	localparam logic [62:0] FP_INF_MAG   = 63'h7FF0_0000_0000_0000;
	localparam logic [63:0] FP_QUIET_BIT = 64'h0008_0000_0000_0000;

	localparam logic [63:0] COEF_B [FILTER_ORDER] = '{
		$realtobits(3.74303762587910E-12),
		$realtobits(3.36873386329119E-11),
		$realtobits(1.31006316905768E-10),
		$realtobits(2.80727821940932E-10),
		$realtobits(3.36873386329119E-10),
		$realtobits(1.57207580286922E-10),
		$realtobits(-1.57207580286922E-10),
		$realtobits(-3.36873386329119E-10),
		$realtobits(-2.80727821940932E-10),
		$realtobits(-1.31006316905768E-10),
		$realtobits(-3.36873386329119E-11),
		$realtobits(-3.74303762587910E-12)
	};

	localparam logic [63:0] COEF_A [FILTER_ORDER] = '{
		$realtobits(1.0),
		$realtobits(-9.42402952073286),
		$realtobits(39.8287330059886),
		$realtobits(-99.2573021975836),
		$realtobits(161.123954282587),
		$realtobits(-177.228962136889),
		$realtobits(132.614858857290),
		$realtobits(-65.3412606795305),
		$realtobits(19.1361903441139),
		$realtobits(-2.22680164996029),
		$realtobits(-0.318010723235478),
		$realtobits(0.0926304179541074)
	};

	typedef struct packed {
		logic signed [31:0] spool_count;
		logic signed [31:0] upper_count;
	} sample_t;

	typedef struct packed {
		logic [63:0] spool_velocity;
		logic [63:0] upper_velocity;
	} velocity_t;

	typedef struct packed {
		logic           start;
		logic [3:0]     step;
		logic           ch;
		logic [K_W-1:0] k;
		logic           capture;
		logic           shift;
		logic           load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic fpu_done;
		logic out_busy;
	} dp_status_t;

	// (direction * 2) * pi, exact since the factor is a power of two or zero
	function automatic logic [63:0] angle_scale(logic [1:0] dir);
		logic [63:0] r;
		case (dir)
			2'b10:   r = 64'hC029_21FB_5444_2D18;
			2'b11:   r = 64'hC019_21FB_5444_2D18;
			2'b01:   r = 64'h4019_21FB_5444_2D18;
			default: r = 64'h0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/encoder_velocity_iir_estimator.sv -----
// Encoder velocity estimator with an eleventh-order IIR filter per channel.
// Sample channel (sample_valid / sample_ready / sample): one word per tick
// holding the signed spool and upper pulley encoder counts. A word is taken
// at a clock edge with valid and ready both high; ready is high only while
// the block is idle.
// Velocity channel (velocity_valid / velocity_ready / velocity): one word per
// sample, both estimates as IEEE-754 double bit patterns in rad/s.
// Configuration: wr_en, wr_index, wr_data write counts per revolution and
// direction per channel, one register per write; write them only while idle.
// Scheduling: every operation runs on one shared double precision
// unit, one operation at a time: per channel two conversions, a scale, a
// divide (one quotient bit per cycle), 23 multiplies and 22 additions or
// subtractions. A sample is worked through to its velocity word before the
// next one is taken; the next sample is taken once that word is registered.
// The output register lets a new sample be taken while the last velocity
// word still waits; if it is still unread when the next one is ready, the
// block holds until velocity_ready.
// Reset clears the filter histories to zero and restores 8192 counts per
// revolution and direction -1 on both channels.
module encoder_velocity_iir_estimator import evi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        velocity_valid,
	input  logic        velocity_ready,
	output velocity_t   velocity,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [16:0] wr_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	evi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	evi_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.sample         (sample),
		.velocity_valid (velocity_valid),
		.velocity_ready (velocity_ready),
		.velocity       (velocity)
	);

endmodule

// ----- rtl/evi_fpu.sv -----
module evi_fpu import evi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  op,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);

	localparam logic [3:0] F_IDLE    = 4'd0;
	localparam logic [3:0] F_PRENORM = 4'd1;
	localparam logic [3:0] F_MUL     = 4'd2;
	localparam logic [3:0] F_DIV     = 4'd3;
	localparam logic [3:0] F_ALIGN   = 4'd4;
	localparam logic [3:0] F_ADDSUB  = 4'd5;
	localparam logic [3:0] F_NORM    = 4'd6;
	localparam logic [3:0] F_DENORM  = 4'd7;
	localparam logic [3:0] F_ROUND   = 4'd8;
	localparam logic [3:0] F_DONE    = 4'd9;

	function automatic logic [55:0] shr_sticky(logic [55:0] v, logic [12:0] sh);
		logic [55:0] r;
		logic [55:0] m;
		if (sh >= 13'd56) begin
			r = {55'b0, |v};
		end else begin
			m = ~({56{1'b1}} << sh[5:0]);
			r = v >> sh[5:0];
			r[0] = r[0] | (|(v & m));
		end
		return r;
	endfunction

	function automatic logic [4:0] lz_step53(logic [52:0] m);
		logic [4:0] r;
		if (m[52])
			r = 5'd0;
		else if (m[52:37] == 16'b0)
			r = 5'd16;
		else if (m[52:49] == 4'b0)
			r = 5'd4;
		else
			r = 5'd1;
		return r;
	endfunction

	logic [3:0]         state_q;
	logic [2:0]         op_q;
	logic               sa_q, sb_q, rs_q, sub_q, ovf_q;
	logic signed [12:0] ea_q, eb_q, re_q;
	logic [52:0]        ma_q, mb_q;
	logic [55:0]        w_q, big_q, small_q;
	logic [10:0]        e_q;
	logic [5:0]         cnt_q;
	logic [105:0]       prod_q;
	logic [63:0]        pp_q;
	logic [53:0]        rem_q;
	logic [54:0]        quo_q;
	logic [63:0]        res_q;

	logic [10:0] ae, be;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sx;
	logic        sp_hit;
	logic [63:0] sp_res;

	always_comb begin
		ae     = a[62:52];
		be     = b[62:52];
		a_nan  = (ae == 11'h7FF) && (a[51:0] != 52'b0);
		b_nan  = (be == 11'h7FF) && (b[51:0] != 52'b0);
		a_inf  = (ae == 11'h7FF) && (a[51:0] == 52'b0);
		b_inf  = (be == 11'h7FF) && (b[51:0] == 52'b0);
		a_zero = (a[62:0] == 63'b0);
		b_zero = (b[62:0] == 63'b0);
		sbe    = b[63] ^ (op == FOP_SUB);
		sx     = a[63] ^ b[63];
		sp_hit = 1'b0;
		sp_res = 64'b0;
		if (op == FOP_CVT) begin
			sp_hit = (a[31:0] == 32'b0);
		end else if (a_nan) begin
			sp_hit = 1'b1;
			sp_res = a | FP_QUIET_BIT;
		end else if (b_nan) begin
			sp_hit = 1'b1;
			sp_res = b | FP_QUIET_BIT;
		end else begin
			case (op)
				FOP_ADD, FOP_SUB: begin
					if (a_inf && b_inf && (a[63] != sbe)) begin
						sp_hit = 1'b1;
						sp_res = FP_DNAN;
					end else if (a_inf) begin
						sp_hit = 1'b1;
						sp_res = a;
					end else if (b_inf) begin
						sp_hit = 1'b1;
						sp_res = {sbe, b[62:0]};
					end
				end
				FOP_MUL: begin
					if ((a_inf && b_zero) || (a_zero && b_inf)) begin
						sp_hit = 1'b1;
						sp_res = FP_DNAN;
					end else if (a_inf || b_inf) begin
						sp_hit = 1'b1;
						sp_res = {sx, FP_INF_MAG};
					end else if (a_zero || b_zero) begin
						sp_hit = 1'b1;
						sp_res = {sx, 63'b0};
					end
				end
				FOP_DIV: begin
					if ((a_inf && b_inf) || (a_zero && b_zero)) begin
						sp_hit = 1'b1;
						sp_res = FP_DNAN;
					end else if (a_inf || b_zero) begin
						sp_hit = 1'b1;
						sp_res = {sx, FP_INF_MAG};
					end else if (a_zero || b_inf) begin
						sp_hit = 1'b1;
						sp_res = {sx, 63'b0};
					end
				end
				default: sp_hit = 1'b1;
			endcase
		end
	end

	// working values of the multi-cycle steps
	logic [4:0]         sha, shb;
	logic               a_ge;
	logic [52:0]        big_m, small_m;
	logic signed [12:0] big_e, small_e, d_e;
	logic [56:0]        sum;
	logic [4:0]         nsh;
	logic [31:0]        mx, my;
	logic [105:0]       pp_add;
	logic [1:0]         prev_idx;
	logic               rem_ge;
	logic [53:0]        rem_nx;
	logic               rnd;
	logic [62:0]        packed_mag;

	always_comb begin
		sha     = lz_step53(ma_q);
		shb     = lz_step53(mb_q);
		a_ge    = {ea_q, ma_q} >= {eb_q, mb_q};
		big_m   = a_ge ? ma_q : mb_q;
		small_m = a_ge ? mb_q : ma_q;
		big_e   = a_ge ? ea_q : eb_q;
		small_e = a_ge ? eb_q : ea_q;
		d_e     = big_e - small_e;
		sum     = sub_q ? ({1'b0, big_q} - {1'b0, small_q}) : ({1'b0, big_q} + {1'b0, small_q});
		if (w_q[55:40] == 16'b0)
			nsh = 5'd16;
		else if (w_q[55:52] == 4'b0)
			nsh = 5'd4;
		else
			nsh = 5'd1;
		mx       = cnt_q[1] ? {11'b0, ma_q[52:32]} : ma_q[31:0];
		my       = cnt_q[0] ? {11'b0, mb_q[52:32]} : mb_q[31:0];
		prev_idx = cnt_q[1:0] - 2'd1;
		case (prev_idx)
			2'd0:    pp_add = {42'b0, pp_q};
			2'd3:    pp_add = {pp_q[41:0], 64'b0};
			default: pp_add = {10'b0, pp_q, 32'b0};
		endcase
		rem_ge     = rem_q >= {1'b0, mb_q};
		rem_nx     = rem_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
		rnd        = w_q[2] & (w_q[1] | w_q[0] | w_q[3]);
		packed_mag = {e_q, w_q[54:3]} + {62'b0, rnd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						if (sp_hit)
							state_q <= F_DONE;
						else if (op == FOP_CVT)
							state_q <= F_NORM;
						else if (op == FOP_ADD || op == FOP_SUB)
							state_q <= F_ALIGN;
						else
							state_q <= F_PRENORM;
					end
				end
				F_PRENORM: begin
					if (ma_q[52] && mb_q[52])
						state_q <= (op_q == FOP_MUL) ? F_MUL : F_DIV;
				end
				F_MUL:    if (cnt_q == 6'd5) state_q <= F_DENORM;
				F_DIV:    if (cnt_q == 6'd55) state_q <= F_DENORM;
				F_ALIGN:  state_q <= F_ADDSUB;
				F_ADDSUB: state_q <= F_NORM;
				F_NORM:   if (w_q == 56'b0 || w_q[55]) state_q <= F_DENORM;
				F_DENORM: state_q <= (w_q == 56'b0) ? F_DONE : F_ROUND;
				F_ROUND:  state_q <= F_DONE;
				F_DONE:   state_q <= F_IDLE;
				default:  state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				op_q  <= op;
				ea_q  <= (ae == 11'b0) ? 13'sd1 : $signed({2'b0, ae});
				eb_q  <= (be == 11'b0) ? 13'sd1 : $signed({2'b0, be});
				ma_q  <= {ae != 11'b0, a[51:0]};
				mb_q  <= {be != 11'b0, b[51:0]};
				sa_q  <= a[63];
				sb_q  <= sbe;
				sub_q <= a[63] ^ sbe;
				res_q <= sp_res;
				cnt_q <= 6'd0;
				prod_q <= 106'b0;
				// integer in the top 32 bits of the working word
				w_q   <= {a[31:0], 24'b0};
				re_q  <= 13'sd1054;
				rs_q  <= a[63];
			end
			F_PRENORM: begin
				ma_q <= ma_q << sha;
				ea_q <= ea_q - $signed({8'b0, sha});
				mb_q <= mb_q << shb;
				eb_q <= eb_q - $signed({8'b0, shb});
				rs_q <= sa_q ^ sb_q;
				if (ma_q >= mb_q) begin
					rem_q <= {1'b0, ma_q};
					re_q  <= ea_q - eb_q + 13'sd1023;
				end else begin
					rem_q <= {ma_q, 1'b0};
					re_q  <= ea_q - eb_q + 13'sd1022;
				end
			end
			F_MUL: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q < 6'd4)
					pp_q <= mx * my;
				if (cnt_q != 6'd0 && cnt_q < 6'd5)
					prod_q <= prod_q + pp_add;
				if (cnt_q == 6'd5) begin
					if (prod_q[105]) begin
						w_q  <= {prod_q[105:51], |prod_q[50:0]};
						re_q <= ea_q + eb_q - 13'sd1022;
					end else begin
						w_q  <= {prod_q[104:50], |prod_q[49:0]};
						re_q <= ea_q + eb_q - 13'sd1023;
					end
				end
			end
			F_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd55) begin
					w_q <= {quo_q, rem_q != 54'b0};
				end else begin
					quo_q <= {quo_q[53:0], rem_ge};
					rem_q <= {rem_nx[52:0], 1'b0};
				end
			end
			F_ALIGN: begin
				big_q   <= {big_m, 3'b0};
				small_q <= shr_sticky({small_m, 3'b0}, d_e);
				re_q    <= big_e;
				rs_q    <= a_ge ? sa_q : sb_q;
			end
			F_ADDSUB: begin
				if (sum == 57'b0) begin
					w_q  <= 56'b0;
					rs_q <= sa_q & sb_q;
				end else if (sum[56]) begin
					w_q  <= {sum[56:2], sum[1] | sum[0]};
					re_q <= re_q + 13'sd1;
				end else begin
					w_q <= sum[55:0];
				end
			end
			F_NORM: begin
				if (w_q != 56'b0 && !w_q[55]) begin
					w_q  <= w_q << nsh;
					re_q <= re_q - $signed({8'b0, nsh});
				end
			end
			F_DENORM: begin
				ovf_q <= (re_q >= 13'sd2047);
				if (w_q == 56'b0) begin
					res_q <= {rs_q, 63'b0};
				end else if (re_q <= 13'sd0) begin
					w_q <= shr_sticky(w_q, 13'sd1 - re_q);
					e_q <= 11'b0;
				end else begin
					e_q <= re_q[10:0];
				end
			end
			F_ROUND: begin
				res_q <= ovf_q ? {rs_q, FP_INF_MAG} : {rs_q, packed_mag};
			end
			default: ;
		endcase
	end

	assign done   = (state_q == F_DONE);
	assign result = res_q;

endmodule

// ----- rtl/evi_datapath.sv -----
module evi_datapath import evi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [16:0] wr_data,
	input  sample_t    sample,
	output logic       velocity_valid,
	input  logic       velocity_ready,
	output velocity_t  velocity
);

	logic [16:0] spool_cpr_q, upper_cpr_q;
	logic [1:0]  spool_dir_q, upper_dir_q;
	logic [31:0] count_q [2];
	logic [63:0] xh_q [2][HIST_LEN];
	logic [63:0] yh_q [2][HIST_LEN];
	logic [63:0] t_q, d_q, x_q, acc_q;
	logic [63:0] vel_q [2];
	velocity_t   velocity_q;
	logic        velocity_valid_q;

	logic [2:0]            fop;
	logic [63:0]           opa, opb;
	logic                  fdone;
	logic [63:0]           fres;
	logic [31:0]           cnt_sel, cnt_mag;
	logic [16:0]           cpr_sel;
	logic [1:0]            dir_sel;
	logic [HIST_IDX_W-1:0] hidx;

	always_comb begin
		cnt_sel = count_q[cmd.ch];
		cnt_mag = cnt_sel[31] ? (~cnt_sel + 32'd1) : cnt_sel;
		cpr_sel = cmd.ch ? upper_cpr_q : spool_cpr_q;
		dir_sel = cmd.ch ? upper_dir_q : spool_dir_q;
		hidx    = HIST_IDX_W'(cmd.k - K_W'(1));
		fop     = FOP_ADD;
		opa     = 64'b0;
		opb     = 64'b0;
		case (cmd.step)
			STEP_CVT_COUNT: begin
				fop = FOP_CVT;
				opa = {cnt_sel[31], 31'b0, cnt_mag};
			end
			STEP_SCALE: begin
				fop = FOP_MUL;
				opa = angle_scale(dir_sel);
				opb = t_q;
			end
			STEP_CVT_CPR: begin
				// zero counts per revolution counts as one
				fop = FOP_CVT;
				opa = {47'b0, (cpr_sel == 17'b0) ? 17'd1 : cpr_sel};
			end
			STEP_DIV: begin
				fop = FOP_DIV;
				opa = t_q;
				opb = d_q;
			end
			STEP_MUL_B0: begin
				fop = FOP_MUL;
				opa = COEF_B[0];
				opb = x_q;
			end
			STEP_MUL_B: begin
				fop = FOP_MUL;
				opa = COEF_B[cmd.k];
				opb = xh_q[cmd.ch][hidx];
			end
			STEP_ADD: begin
				fop = FOP_ADD;
				opa = acc_q;
				opb = t_q;
			end
			STEP_MUL_A: begin
				fop = FOP_MUL;
				opa = COEF_A[cmd.k];
				opb = yh_q[cmd.ch][hidx];
			end
			STEP_SUB: begin
				fop = FOP_SUB;
				opa = acc_q;
				opb = t_q;
			end
			default: fop = FOP_ADD;
		endcase
	end

	evi_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (fop),
		.a      (opa),
		.b      (opb),
		.done   (fdone),
		.result (fres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spool_cpr_q      <= CPR_RESET;
			upper_cpr_q      <= CPR_RESET;
			spool_dir_q      <= DIR_RESET;
			upper_dir_q      <= DIR_RESET;
			velocity_valid_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				for (int i = 0; i < HIST_LEN; i++) begin
					xh_q[c][i] <= 64'b0;
					yh_q[c][i] <= 64'b0;
				end
			end
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SPOOL_CPR: spool_cpr_q <= wr_data;
					REG_UPPER_CPR: upper_cpr_q <= wr_data;
					REG_SPOOL_DIR: spool_dir_q <= wr_data[1:0];
					REG_UPPER_DIR: upper_dir_q <= wr_data[1:0];
					default: ;
				endcase
			end
			// newest entry in slot zero
			if (cmd.shift) begin
				xh_q[cmd.ch][0] <= x_q;
				yh_q[cmd.ch][0] <= acc_q;
				for (int i = 1; i < HIST_LEN; i++) begin
					xh_q[cmd.ch][i] <= xh_q[cmd.ch][i-1];
					yh_q[cmd.ch][i] <= yh_q[cmd.ch][i-1];
				end
			end
			if (cmd.load_out)
				velocity_valid_q <= 1'b1;
			else if (velocity_ready)
				velocity_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			count_q[0] <= sample.spool_count;
			count_q[1] <= sample.upper_count;
		end
		if (fdone) begin
			case (cmd.step)
				STEP_CVT_CPR:                      d_q   <= fres;
				STEP_DIV:                          x_q   <= fres;
				STEP_MUL_B0, STEP_ADD, STEP_SUB:   acc_q <= fres;
				default:                           t_q   <= fres;
			endcase
		end
		if (cmd.shift)
			vel_q[cmd.ch] <= acc_q;
		if (cmd.load_out) begin
			velocity_q.spool_velocity <= vel_q[0];
			velocity_q.upper_velocity <= vel_q[1];
		end
	end

	assign status.fpu_done = fdone;
	assign status.out_busy = velocity_valid_q & ~velocity_ready;
	assign velocity_valid  = velocity_valid_q;
	assign velocity        = velocity_q;

endmodule

// ----- rtl/evi_ctrl.sv -----
module evi_ctrl import evi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]     state_q;
	logic [3:0]     step_q;
	logic           ch_q;
	logic [K_W-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_CVT_COUNT;
			ch_q    <= 1'b0;
			k_q     <= K_W'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						step_q  <= STEP_CVT_COUNT;
						ch_q    <= 1'b0;
						k_q     <= K_W'(1);
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.fpu_done) begin
						state_q <= S_ISSUE;
						case (step_q)
							STEP_CVT_COUNT: step_q <= STEP_SCALE;
							STEP_SCALE:     step_q <= STEP_CVT_CPR;
							STEP_CVT_CPR:   step_q <= STEP_DIV;
							STEP_DIV:       step_q <= STEP_MUL_B0;
							STEP_MUL_B0:    step_q <= STEP_MUL_B;
							STEP_MUL_B:     step_q <= STEP_ADD;
							STEP_ADD:       step_q <= STEP_MUL_A;
							STEP_MUL_A:     step_q <= STEP_SUB;
							STEP_SUB: begin
								if (k_q == K_W'(HIST_LEN)) begin
									state_q <= S_SHIFT;
								end else begin
									k_q    <= k_q + K_W'(1);
									step_q <= STEP_MUL_B;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SHIFT: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						k_q     <= K_W'(1);
						step_q  <= STEP_CVT_COUNT;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold while the previous word is still unread
					if (!status.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.start    = (state_q == S_ISSUE);
		cmd.step     = step_q;
		cmd.ch       = ch_q;
		cmd.k        = k_q;
		cmd.capture  = (state_q == S_IDLE) && sample_valid;
		cmd.shift    = (state_q == S_SHIFT);
		cmd.load_out = (state_q == S_OUT) && !status.out_busy;
	end

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("operation start held longer than one cycle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.fpu_done |-> (state_q == S_WAIT))
		else $error("arithmetic unit finished while no operation was awaited");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q >= K_W'(1)) && (k_q <= K_W'(HIST_LEN)))
		else $error("tap counter out of range");

	a_load_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift && ch_q |=> (state_q == S_OUT))
		else $error("result not offered after second channel");

endmodule

// ----- bench/velocity_checker.sv -----
`timescale 1ns / 100ps

module velocity_checker import evi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  sample_t     sample,
	input  logic        velocity_valid,
	input  logic        velocity_ready,
	input  velocity_t   velocity,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [16:0] wr_data,
	output int          failures,
	output int          pending
);

	localparam real PI_R = 3.14159265358979323846;

	logic [16:0] cpr_cfg [2];
	logic [1:0]  dir_cfg [2];
	real         angle_hist [2][HIST_LEN];
	real         vel_hist [2][HIST_LEN];
	velocity_t   expected_words [$];

	function automatic real count_to_angle(logic signed [31:0] cnt, logic [1:0] d,
			logic [16:0] c);
		int  sd;
		real den;
		sd  = $signed(d);
		den = (c == 0) ? 1.0 : real'(c);
		return (real'(sd * 2) * PI_R) * real'(cnt) / den;
	endfunction

	function automatic real filter_channel(int ch, real x);
		real acc;
		acc = $bitstoreal(COEF_B[0]) * x;
		for (int k = 1; k < FILTER_ORDER; k++) begin
			acc = acc + $bitstoreal(COEF_B[k]) * angle_hist[ch][k-1];
			acc = acc - $bitstoreal(COEF_A[k]) * vel_hist[ch][k-1];
		end
		for (int k = HIST_LEN - 1; k > 0; k--) begin
			angle_hist[ch][k] = angle_hist[ch][k-1];
			vel_hist[ch][k]   = vel_hist[ch][k-1];
		end
		angle_hist[ch][0] = x;
		vel_hist[ch][0]   = acc;
		return acc;
	endfunction

	function automatic velocity_t predict_velocity(sample_t s);
		velocity_t v;
		real       xs, xu;
		xs = count_to_angle(s.spool_count, dir_cfg[0], cpr_cfg[0]);
		xu = count_to_angle(s.upper_count, dir_cfg[1], cpr_cfg[1]);
		v.spool_velocity = $realtobits(filter_channel(0, xs));
		v.upper_velocity = $realtobits(filter_channel(1, xu));
		return v;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		velocity_t exp_w;
		if (!arst_n) begin
			cpr_cfg[0] = CPR_RESET;
			cpr_cfg[1] = CPR_RESET;
			dir_cfg[0] = DIR_RESET;
			dir_cfg[1] = DIR_RESET;
			for (int c = 0; c < 2; c++)
				for (int k = 0; k < HIST_LEN; k++) begin
					angle_hist[c][k] = 0.0;
					vel_hist[c][k]   = 0.0;
				end
			expected_words.delete();
			failures = 0;
		end else begin
			if (velocity_valid && velocity_ready) begin
				if (expected_words.size() == 0) begin
					failures++;
					$display("%0t: unexpected velocity word %h", $time, velocity);
				end else begin
					exp_w = expected_words.pop_front();
					if (exp_w.spool_velocity !== velocity.spool_velocity) begin
						failures++;
						$display("%0t: spool_velocity expected %h actual %h", $time,
							exp_w.spool_velocity, velocity.spool_velocity);
					end
					if (exp_w.upper_velocity !== velocity.upper_velocity) begin
						failures++;
						$display("%0t: upper_velocity expected %h actual %h", $time,
							exp_w.upper_velocity, velocity.upper_velocity);
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_words.insert(expected_words.size(), predict_velocity(sample));
			if (wr_en) begin
				case (wr_index)
					REG_SPOOL_CPR: cpr_cfg[0] = wr_data;
					REG_UPPER_CPR: cpr_cfg[1] = wr_data;
					REG_SPOOL_DIR: dir_cfg[0] = wr_data[1:0];
					REG_UPPER_DIR: dir_cfg[1] = wr_data[1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench import evi_pkg::*;;

	localparam int  CYCLE_LIMIT = 8000000;
	localparam int  N_PHASES    = 7;
	localparam int  PHASE_ITEMS = 170;
	localparam int  HOLD_CYCLES = 5000;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_ready;
	sample_t     sample;
	logic        velocity_valid;
	logic        velocity_ready;
	velocity_t   velocity;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [16:0] wr_data;
	int          failures;
	int          pending;
	int          cycles;
	bit          quiet;
	bit          hold_req;
	logic signed [31:0] spool_pos;
	logic signed [31:0] upper_pos;

	encoder_velocity_iir_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.velocity_valid(velocity_valid), .velocity_ready(velocity_ready),
		.velocity(velocity),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	velocity_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.velocity_valid(velocity_valid), .velocity_ready(velocity_ready),
		.velocity(velocity),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// receiver: short random stalls, one long hold-off on request
	initial begin
		velocity_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				velocity_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				velocity_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				velocity_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(logic signed [31:0] sc, logic signed [31:0] uc);
		sample_valid       <= 1'b1;
		sample.spool_count <= sc;
		sample.upper_count <= uc;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apply_setting(logic [16:0] scpr, logic [16:0] ucpr,
			logic [1:0] sdir, logic [1:0] udir);
		write_reg(REG_SPOOL_CPR, scpr);
		write_reg(REG_UPPER_CPR, ucpr);
		write_reg(REG_SPOOL_DIR, {15'($urandom), sdir});
		write_reg(REG_UPPER_DIR, {15'($urandom), udir});
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// mostly a random walk like a real encoder, with the odd wild jump
	task automatic send_walk(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				spool_pos = $urandom;
				upper_pos = $urandom;
			end else begin
				spool_pos = spool_pos + $signed($urandom_range(0, 400)) - 200;
				upper_pos = upper_pos + $signed($urandom_range(0, 400)) - 200;
			end
			send_word(spool_pos, upper_pos);
		end
	endtask

	logic [16:0] set_scpr [N_PHASES] = '{17'd8192, 17'd1, 17'd0, 17'd65536,
		17'd131071, 17'd1000, 17'd65535};
	logic [16:0] set_ucpr [N_PHASES] = '{17'd8192, 17'd65536, 17'd131071, 17'd1,
		17'd0, 17'd4096, 17'd3600};
	logic [1:0]  set_sdir [N_PHASES] = '{2'b11, 2'b01, 2'b00, 2'b10, 2'b01, 2'b11, 2'b01};
	logic [1:0]  set_udir [N_PHASES] = '{2'b11, 2'b10, 2'b01, 2'b01, 2'b00, 2'b10, 2'b11};

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		wr_en        = 1'b0;
		wr_index     = REG_SPOOL_CPR;
		wr_data      = '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		spool_pos    = 0;
		upper_pos    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes under reset settings
		send_word(0, 0);
		send_word(32'sh7FFFFFFF, 32'sh80000000);
		send_word(32'sh80000000, 32'sh7FFFFFFF);
		send_word(-1, 1);
		send_word(1, -1);
		send_word(32'sh55555555, 32'shAAAAAAAA);
		send_word(32'shAAAAAAAA, 32'sh55555555);
		send_word(8192, -8192);
		for (int i = 0; i < 8; i++) send_word(100 * i, -50 * i);
		for (int i = 0; i < 4; i++) send_word(0, 0);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			apply_setting(set_scpr[p], set_ucpr[p], set_sdir[p], set_udir[p]);
			if (p == 2) hold_req = 1'b1;
			if (p == N_PHASES - 1) quiet = 1'b1;
			send_walk(PHASE_ITEMS);
		end

		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
